// ===== src/bcr_pkg.sv =====
`default_nettype none

package bcr_pkg;

  // Coordinate, dimension and configuration index widths.
  localparam int CW = 12;
  localparam int FW = 13;
  localparam int IW = 3;

  // Divider: quotient bits (padded to a multiple of RB), bits per stage, stage count.
  localparam int QW = 26;
  localparam int RB = 2;
  localparam int NS = QW / RB;

  // Signed offset carried beside the division, and the signed result width.
  localparam int OW = 15;
  localparam int RW = QW + 2;

  // Input register, two preparation stages, divider stages, two finishing stages.
  localparam int LAT = 3 + NS + 2;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam logic [FW-1:0] DIM_RESET = 13'd4096;

  localparam logic [IW-1:0] REG_BEND_MODE  = 3'd0;
  localparam logic [IW-1:0] REG_SPLIT_X    = 3'd1;
  localparam logic [IW-1:0] REG_TARGET_X   = 3'd2;
  localparam logic [IW-1:0] REG_SPLIT_Y    = 3'd3;
  localparam logic [IW-1:0] REG_TARGET_Y   = 3'd4;
  localparam logic [IW-1:0] REG_SRC_WIDTH  = 3'd5;
  localparam logic [IW-1:0] REG_SRC_HEIGHT = 3'd6;
  localparam logic [IW-1:0] REG_COPY_WIDTH = 3'd7;

  localparam logic [1:0] MODE_MIRROR = 2'd0;

  // Clamped configuration as seen by the datapath.
  typedef struct packed {
    logic          mirror;
    logic          bend_y;
    logic [CW-1:0] sx;
    logic [CW-1:0] tx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ty;
    logic [FW-1:0] src_width;
    logic [FW-1:0] src_height;
  } cfg_t;

  // One coordinate travelling through the divider.
  typedef struct packed {
    logic                 neg;
    logic [QW-1:0]        num;
    logic [QW-1:0]        quo;
    logic [FW:0]          rem;
    logic [FW-1:0]        den;
    logic signed [OW-1:0] offset;
  } divw_t;

  // Limit a split or target value to dim-1, treating a zero dimension as limit 0.
  function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] v,
                                              input logic [FW-1:0] dim);
    logic [FW-1:0] lim;
    lim = (dim == '0) ? '0 : dim - 1'b1;
    clamp_dim = ({1'b0, v} > lim) ? lim[CW-1:0] : v;
  endfunction

endpackage

`default_nettype wire

// ===== src/bcr_regs.sv =====
`default_nettype none

module bcr_regs (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [bcr_pkg::IW-1:0]   cfg_index,
  input  wire logic [bcr_pkg::FW-1:0]   cfg_data,
  output bcr_pkg::cfg_t                 cfg
);

  logic [1:0]             bend_mode;
  logic [bcr_pkg::CW-1:0] split_x;
  logic [bcr_pkg::CW-1:0] target_x;
  logic [bcr_pkg::CW-1:0] split_y;
  logic [bcr_pkg::CW-1:0] target_y;
  logic [bcr_pkg::FW-1:0] src_width;
  logic [bcr_pkg::FW-1:0] src_height;
  logic [bcr_pkg::FW-1:0] copy_width;
  bcr_pkg::cfg_t          cfg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bend_mode  <= '0;
      split_x    <= '0;
      target_x   <= '0;
      split_y    <= '0;
      target_y   <= '0;
      src_width  <= bcr_pkg::DIM_RESET;
      src_height <= bcr_pkg::DIM_RESET;
      copy_width <= bcr_pkg::DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bcr_pkg::REG_BEND_MODE:  bend_mode  <= cfg_data[1:0];
        bcr_pkg::REG_SPLIT_X:    split_x    <= cfg_data[bcr_pkg::CW-1:0];
        bcr_pkg::REG_TARGET_X:   target_x   <= cfg_data[bcr_pkg::CW-1:0];
        bcr_pkg::REG_SPLIT_Y:    split_y    <= cfg_data[bcr_pkg::CW-1:0];
        bcr_pkg::REG_TARGET_Y:   target_y   <= cfg_data[bcr_pkg::CW-1:0];
        bcr_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        bcr_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        bcr_pkg::REG_COPY_WIDTH: copy_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mode three behaves as mode two, so the row bend follows the upper mode bit.
  always_comb begin
    cfg_next.mirror     = (bend_mode == bcr_pkg::MODE_MIRROR);
    cfg_next.bend_y     = bend_mode[1];
    cfg_next.sx         = bcr_pkg::clamp_dim(split_x, copy_width);
    cfg_next.tx         = bcr_pkg::clamp_dim(target_x, copy_width);
    cfg_next.sy         = bcr_pkg::clamp_dim(split_y, src_height);
    cfg_next.ty         = bcr_pkg::clamp_dim(target_y, src_height);
    cfg_next.src_width  = src_width;
    cfg_next.src_height = src_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mirror     <= 1'b1;
      cfg.bend_y     <= 1'b0;
      cfg.sx         <= '0;
      cfg.tx         <= '0;
      cfg.sy         <= '0;
      cfg.ty         <= '0;
      cfg.src_width  <= bcr_pkg::DIM_RESET;
      cfg.src_height <= bcr_pkg::DIM_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bcr_prep.sv =====
`default_nettype none

module bcr_prep (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [bcr_pkg::CW-1:0] c,
  input  wire logic [bcr_pkg::CW-1:0] s,
  input  wire logic [bcr_pkg::CW-1:0] t,
  input  wire logic [bcr_pkg::FW-1:0] full,
  input  wire logic                   mirror,
  input  wire logic                   bend,
  output bcr_pkg::divw_t              d_out
);

  localparam int CW = bcr_pkg::CW;
  localparam int FW = bcr_pkg::FW;
  localparam int OW = bcr_pkg::OW;

  logic                 lower;
  logic [CW-1:0]        diff_cs;
  logic signed [FW:0]   full_t;
  logic signed [FW:0]   full_t_neg;
  logic signed [FW:0]   full_s;
  logic signed [FW:0]   mirr;
  logic [CW-1:0]        a_next;
  logic [FW-1:0]        b_next;
  logic [FW-1:0]        den_next;
  logic                 neg_next;
  logic signed [OW-1:0] off_next;

  logic [CW-1:0]        a_r;
  logic [FW-1:0]        b_r;
  logic [FW-1:0]        den_r;
  logic                 neg_r;
  logic signed [OW-1:0] off_r;
  logic [CW+FW-1:0]     prod;
  bcr_pkg::divw_t       d_next;

  // Every case becomes offset + floor(sign * a * b / den); a direct value has a = b = 0.
  always_comb begin
    lower      = (c < s);
    diff_cs    = c - s;
    full_t     = $signed({1'b0, full}) - $signed({2'b0, t});
    full_t_neg = -full_t;
    full_s     = $signed({1'b0, full}) - $signed({2'b0, s});
    mirr       = $signed({1'b0, s, 1'b0}) - $signed({2'b0, c});
    a_next     = '0;
    b_next     = '0;
    neg_next   = 1'b0;
    den_next   = FW'(1);
    off_next   = $signed({3'b0, c});
    if (mirror) begin
      if (!lower && !mirr[FW]) begin
        off_next = $signed({mirr[FW], mirr});
      end
    end else if (bend) begin
      if (lower) begin
        a_next   = c;
        b_next   = {1'b0, t};
        den_next = {1'b0, s};
        off_next = '0;
      end else if (full_s <= 0) begin
        off_next = $signed({3'b0, t});
      end else begin
        a_next   = diff_cs;
        neg_next = full_t[FW];
        b_next   = full_t[FW] ? full_t_neg[FW-1:0] : full_t[FW-1:0];
        den_next = full_s[FW-1:0];
        off_next = $signed({3'b0, t});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_next;
      b_r   <= b_next;
      den_r <= den_next;
      neg_r <= neg_next;
      off_r <= off_next;
    end
  end

  always_comb begin
    prod          = a_r * b_r;
    d_next.neg    = neg_r;
    d_next.num    = bcr_pkg::QW'(prod);
    d_next.quo    = '0;
    d_next.rem    = '0;
    d_next.den    = den_r;
    d_next.offset = off_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bcr_div_stage.sv =====
`default_nettype none

module bcr_div_stage (
  input  wire logic     clk,
  input  wire logic     en,
  input  wire bcr_pkg::divw_t d_in,
  output bcr_pkg::divw_t d_out
);

  localparam int FW = bcr_pkg::FW;
  localparam int QW = bcr_pkg::QW;

  bcr_pkg::divw_t d_next;

  // Restoring division, RB quotient bits per stage, numerator consumed from the top.
  always_comb begin
    d_next = d_in;
    for (int k = 0; k < bcr_pkg::RB; k++) begin
      d_next.rem = {d_next.rem[FW-1:0], d_next.num[QW-1]};
      d_next.num = {d_next.num[QW-2:0], 1'b0};
      if (d_next.rem >= {1'b0, d_next.den}) begin
        d_next.rem = d_next.rem - {1'b0, d_next.den};
        d_next.quo = {d_next.quo[QW-2:0], 1'b1};
      end else begin
        d_next.quo = {d_next.quo[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bcr_post.sv =====
`default_nettype none

module bcr_post #(
  parameter int MAX_DIM = bcr_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire bcr_pkg::divw_t         d_in,
  output logic [bcr_pkg::CW-1:0]      coord
);

  localparam int OW = bcr_pkg::OW;
  localparam int RW = bcr_pkg::RW;
  localparam logic signed [RW-1:0] LIMIT = RW'(MAX_DIM - 1);

  logic signed [RW-1:0] mag;
  logic signed [RW-1:0] qs_next;
  logic signed [RW-1:0] qs;
  logic signed [OW-1:0] off;
  logic signed [RW-1:0] sum;
  logic [bcr_pkg::CW-1:0] coord_next;

  // Floor of a negative quotient: -q when exact, otherwise -q-1.
  always_comb begin
    mag = $signed({2'b0, d_in.quo});
    if (d_in.neg) begin
      qs_next = (d_in.rem != '0) ? ~mag : -mag;
    end else begin
      qs_next = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs  <= qs_next;
      off <= d_in.offset;
    end
  end

  always_comb begin
    sum = qs + $signed({{(RW-OW){off[OW-1]}}, off});
    if (sum < 0) begin
      coord_next = '0;
    end else if (sum > LIMIT) begin
      coord_next = LIMIT[bcr_pkg::CW-1:0];
    end else begin
      coord_next = sum[bcr_pkg::CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord <= coord_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bend_coordinate_remap.sv =====
// Channel  Direction  Handshake              Payload
// config   in         cfg_write              cfg_index, cfg_data
// input    in         in_valid / in_ready    dest_col, dest_row
// output   out        out_valid / out_ready  source_col, source_row
//
// One transaction is taken per clock cycle unless the output is stalled; a result
// passes through 18 register stages, among them the thirteen divider stages that
// each retire two quotient bits.
// Reset clears the valid bits of every stage and loads the configuration defaults.
// When the output register holds a result that is not taken, the whole pipeline
// freezes in place, so nothing is dropped or repeated.
`default_nettype none

module bend_coordinate_remap #(
  parameter int MAX_DIM = bcr_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [bcr_pkg::IW-1:0] cfg_index,
  input  wire logic [bcr_pkg::FW-1:0] cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [bcr_pkg::CW-1:0] dest_col,
  input  wire logic [bcr_pkg::CW-1:0] dest_row,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [bcr_pkg::CW-1:0]      source_col,
  output logic [bcr_pkg::CW-1:0]      source_row
);

  localparam int NS  = bcr_pkg::NS;
  localparam int LAT = bcr_pkg::LAT;

  bcr_pkg::cfg_t          cfg;
  logic                   adv;
  logic [LAT-1:0]         vld;
  logic [bcr_pkg::CW-1:0] col_r;
  logic [bcr_pkg::CW-1:0] row_r;
  bcr_pkg::divw_t         col_pipe [0:NS];
  bcr_pkg::divw_t         row_pipe [0:NS];

  // Both the written value and the clamped configuration are registered before a
  // write takes effect for the transactions at the preparation stage.
  bcr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The pipeline moves as one unit whenever the output register is free or
  // being emptied in the same cycle.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Input register; the payload needs no reset since the valid bit qualifies it.
  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= dest_col;
      row_r <= dest_row;
    end
  end

  // The column uses the mirror in mode 0 and the bend otherwise; the row is
  // only bent in modes 2 and 3.
  bcr_prep u_prep_col (
    .clk    (clk),
    .en     (adv),
    .c      (col_r),
    .s      (cfg.sx),
    .t      (cfg.tx),
    .full   (cfg.src_width),
    .mirror (cfg.mirror),
    .bend   (1'b1),
    .d_out  (col_pipe[0])
  );

  bcr_prep u_prep_row (
    .clk    (clk),
    .en     (adv),
    .c      (row_r),
    .s      (cfg.sy),
    .t      (cfg.ty),
    .full   (cfg.src_height),
    .mirror (1'b0),
    .bend   (cfg.bend_y),
    .d_out  (row_pipe[0])
  );

  // Two independent divider chains, one per coordinate.
  for (genvar i = 0; i < NS; i++) begin : g_div
    bcr_div_stage u_col (
      .clk   (clk),
      .en    (adv),
      .d_in  (col_pipe[i]),
      .d_out (col_pipe[i+1])
    );
    bcr_div_stage u_row (
      .clk   (clk),
      .en    (adv),
      .d_in  (row_pipe[i]),
      .d_out (row_pipe[i+1])
    );
  end

  // Sign correction, offset addition and saturation; the last register of
  // each is the output register.
  bcr_post #(.MAX_DIM(MAX_DIM)) u_post_col (
    .clk   (clk),
    .en    (adv),
    .d_in  (col_pipe[NS]),
    .coord (source_col)
  );

  bcr_post #(.MAX_DIM(MAX_DIM)) u_post_row (
    .clk   (clk),
    .en    (adv),
    .d_in  (row_pipe[NS]),
    .coord (source_row)
  );

endmodule

`default_nettype wire

// ===== src/bcr_checker.sv =====
`default_nettype none

module bcr_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [bcr_pkg::CW-1:0] source_col,
  input wire logic [bcr_pkg::CW-1:0] source_row
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(source_col) && $stable(source_row))
    else $error("output transaction changed while stalled");

  // With the output register empty the block must take a new transaction.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  // A taken result frees the whole pipeline in the same cycle.
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

  // Reset empties the pipeline.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present straight after reset");

  // An input held valid across a stall is still offered to the block.
  a_in_wait: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn before acceptance");

endmodule

bind bend_coordinate_remap bcr_checker u_bcr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .source_col (source_col),
  .source_row (source_row)
);

`default_nettype wire
